### src/sbr_pkg.sv
// ----------------------------------------------------------------------------
// sbr_pkg
// shared types, codes and reset values for the seatbelt reminder controller
// ----------------------------------------------------------------------------
package sbr_pkg;

  localparam int unsigned SpeedW = 8;
  localparam int unsigned TimerW = 16;

  // largest speed report that is taken into account
  localparam logic [SpeedW-1:0] MaxValidSpeed = 8'd239;
  localparam logic [TimerW-1:0] TimerMax      = 16'hFFFF;

  // configuration reset values
  localparam logic [SpeedW-1:0] LowSpeedRst       = 8'd10;
  localparam logic [TimerW-1:0] SpeedDurationRst  = 16'd10;
  localparam logic [TimerW-1:0] BuzzerDelayRst    = 16'd10;
  localparam logic [TimerW-1:0] UnbuckleLimitRst  = 16'd30;
  localparam logic [TimerW-1:0] BuzzerTimeoutRst  = 16'd60;

  // event codes
  typedef enum logic [1:0] {
    FUNC_TICK    = 2'd0,
    FUNC_SPEED   = 2'd1,
    FUNC_BELT    = 2'd2,
    FUNC_RESTART = 2'd3
  } func_e;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_LOW_SPEED      = 3'd0,
    CFG_SPEED_DURATION = 3'd1,
    CFG_BUZZER_DELAY   = 3'd2,
    CFG_UNBUCKLE_LIMIT = 3'd3,
    CFG_BUZZER_TIMEOUT = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CMD_NONE = 2'd0,
    CMD_ON   = 2'd1,
    CMD_OFF  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    MSG_NONE = 2'd0,
    MSG_OFF  = 2'd1,
    MSG_ON   = 2'd2
  } msg_e;

  // controller mode, one-hot
  typedef enum logic [4:0] {
    MODE_IDLE     = 5'b00001,
    MODE_ARMED    = 5'b00010,
    MODE_BUZZING  = 5'b00100,
    MODE_REPORTED = 5'b01000,
    MODE_QUIET    = 5'b10000
  } mode_e;

  // external mode codes
  localparam logic [2:0] ModeCodeIdle     = 3'd0;
  localparam logic [2:0] ModeCodeArmed    = 3'd1;
  localparam logic [2:0] ModeCodeBuzzing  = 3'd2;
  localparam logic [2:0] ModeCodeReported = 3'd3;
  localparam logic [2:0] ModeCodeQuiet    = 3'd4;

  typedef struct packed {
    logic [SpeedW-1:0] low_speed;
    logic [TimerW-1:0] speed_duration;
    logic [TimerW-1:0] buzzer_delay;
    logic [TimerW-1:0] unbuckle_limit;
    logic [TimerW-1:0] buzzer_timeout;
  } cfg_t;

  typedef struct packed {
    func_e             func;
    logic [SpeedW-1:0] road_speed;
    logic              belt_buckled;
    logic              sensor_buckled;
  } item_t;

  typedef struct packed {
    mode_e             mode;
    logic [TimerW-1:0] speed_timer;
    logic [TimerW-1:0] belt_timer;
  } state_t;

  typedef struct packed {
    cmd_e              buzzer_cmd;
    logic [TimerW-1:0] buzz_seconds;
    msg_e              message;
    logic [2:0]        mode;
  } result_t;

  function automatic logic [2:0] mode_code(mode_e m);
    logic [2:0] code;
    case (m)
      MODE_ARMED:    code = ModeCodeArmed;
      MODE_BUZZING:  code = ModeCodeBuzzing;
      MODE_REPORTED: code = ModeCodeReported;
      MODE_QUIET:    code = ModeCodeQuiet;
      default:       code = ModeCodeIdle;
    endcase
    return code;
  endfunction

  function automatic logic [TimerW-1:0] sat_inc(logic [TimerW-1:0] v);
    return (v == TimerMax) ? TimerMax : v + TimerW'(1);
  endfunction

endpackage

### src/sbr_step.sv
// ----------------------------------------------------------------------------
// sbr_step
// next-state and result logic for one event word
// ----------------------------------------------------------------------------
module sbr_step (
  input  sbr_pkg::item_t   item_i,
  input  sbr_pkg::state_t  state_i,
  input  sbr_pkg::cfg_t    cfg_i,
  output sbr_pkg::state_t  state_o,
  output sbr_pkg::result_t result_o
);
  import sbr_pkg::*;

  mode_e             mode;
  state_t            nx;
  cmd_e              cmd;
  msg_e              msg;
  logic [TimerW-1:0] st_inc;
  logic [TimerW-1:0] bt_inc;
  logic              restart_speed;

  // anything outside the five modes behaves as idle
  always_comb begin
    case (state_i.mode)
      MODE_ARMED, MODE_BUZZING, MODE_REPORTED, MODE_QUIET: mode = state_i.mode;
      default:                                             mode = MODE_IDLE;
    endcase
  end

  assign st_inc = sat_inc(state_i.speed_timer);
  assign bt_inc = sat_inc(state_i.belt_timer);

  always_comb begin
    nx            = state_i;
    nx.mode       = mode;
    cmd           = CMD_NONE;
    msg           = MSG_NONE;
    restart_speed = 1'b0;

    case (item_i.func)
      FUNC_TICK: begin
        nx.speed_timer = st_inc;
        if (st_inc >= cfg_i.speed_duration) begin
          nx.speed_timer = '0;
          nx.belt_timer  = '0;
          case (mode)
            MODE_ARMED:    nx.mode = MODE_IDLE;
            MODE_BUZZING: begin
              cmd     = CMD_OFF;
              nx.mode = MODE_IDLE;
            end
            MODE_REPORTED: begin
              cmd     = CMD_OFF;
              nx.mode = MODE_QUIET;
            end
            MODE_QUIET: begin
              cmd     = CMD_ON;
              nx.mode = MODE_REPORTED;
            end
            default:       nx.mode = MODE_ARMED;
          endcase
        end else if (mode == MODE_ARMED) begin
          nx.belt_timer = bt_inc;
          if (bt_inc >= cfg_i.buzzer_delay) begin
            if (!item_i.sensor_buckled) begin
              cmd            = CMD_ON;
              nx.mode        = MODE_BUZZING;
              nx.speed_timer = '0;
            end
            nx.belt_timer = '0;
          end
        end else if (mode == MODE_BUZZING) begin
          nx.belt_timer = bt_inc;
          if (bt_inc >= cfg_i.unbuckle_limit) begin
            msg            = MSG_OFF;
            nx.mode        = MODE_REPORTED;
            nx.speed_timer = '0;
            nx.belt_timer  = '0;
          end
        end
      end
      FUNC_SPEED: begin
        if (item_i.road_speed <= MaxValidSpeed) begin
          if (mode == MODE_IDLE || mode == MODE_QUIET) begin
            restart_speed = item_i.road_speed < cfg_i.low_speed;
          end else begin
            restart_speed = item_i.road_speed > cfg_i.low_speed;
          end
        end
        if (restart_speed) begin
          nx.speed_timer = '0;
        end
      end
      FUNC_BELT: begin
        if (item_i.belt_buckled) begin
          case (mode)
            MODE_ARMED:    nx.belt_timer = '0;
            MODE_BUZZING: begin
              cmd            = CMD_OFF;
              nx.mode        = MODE_ARMED;
              nx.speed_timer = '0;
              nx.belt_timer  = '0;
            end
            MODE_REPORTED: begin
              cmd            = CMD_OFF;
              msg            = MSG_ON;
              nx.mode        = MODE_ARMED;
              nx.speed_timer = '0;
              nx.belt_timer  = '0;
            end
            MODE_QUIET: begin
              msg            = MSG_ON;
              nx.mode        = MODE_IDLE;
              nx.speed_timer = '0;
              nx.belt_timer  = '0;
            end
            default: ;
          endcase
        end
      end
      default: begin
        if (mode == MODE_BUZZING || mode == MODE_REPORTED || mode == MODE_QUIET) begin
          if (mode != MODE_QUIET) begin
            cmd = CMD_OFF;
          end
          nx.mode        = MODE_IDLE;
          nx.speed_timer = '0;
          nx.belt_timer  = '0;
        end
      end
    endcase
  end

  assign state_o               = nx;
  assign result_o.buzzer_cmd   = cmd;
  assign result_o.buzz_seconds = (cmd == CMD_ON) ? cfg_i.buzzer_timeout : '0;
  assign result_o.message      = msg;
  assign result_o.mode         = mode_code(nx.mode);

endmodule

### src/seatbelt_reminder_controller.sv
// ----------------------------------------------------------------------------
// seatbelt_reminder_controller
// seatbelt reminder: mode tracking, buzzer commands and belt messages
// ----------------------------------------------------------------------------
//
//  channel  | handshake                | payload
//  ---------+--------------------------+-----------------------------------------
//  in       | in_valid_i / in_stall_o  | func_i, road_speed_i, belt_buckled_i,
//           |                          | sensor_buckled_i
//  out      | out_valid_o / out_stall_i| buzzer_cmd_o, buzz_seconds_o, message_o,
//           |                          | mode_o
//  cfg      | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
//  every event word yields one result word, through the input register and
//  then the result register; one word per cycle sustained while out_stall_i
//  is low: input register, one pass of step logic, result register; mode
//  and timers update as a word moves into the result register
//  reset clears mode and both timers and loads the register defaults
//  out_stall_i holds the result register; the input register then fills and
//  in_stall_o rises only while a word waits there behind a held result
//  config writes are always ready and are registered
//
module seatbelt_reminder_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  // event input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [7:0]  road_speed_i,
  input  logic        belt_buckled_i,
  input  logic        sensor_buckled_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  buzzer_cmd_o,
  output logic [15:0] buzz_seconds_o,
  output logic [1:0]  message_o,
  output logic [2:0]  mode_o,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import sbr_pkg::*;

  // configuration registers
  cfg_t    cfg_q, cfg_d;

  // controller state: mode and the two second counters
  state_t  state_q, state_d;

  // input stage
  logic    in_valid_q, in_valid_d;
  item_t   in_q, in_d;

  // result stage
  logic    out_valid_q, out_valid_d;
  result_t res_q, res_d;

  logic    out_free;
  logic    advance;
  logic    in_accept;

  // ---- handshake ----------------------------------------------------------
  // result register can take a word when empty or being drained this cycle
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    in_d       = in_q;
    if (in_accept) begin
      in_valid_d        = 1'b1;
      in_d.func         = func_e'(func_i);
      in_d.road_speed   = road_speed_i;
      in_d.belt_buckled = belt_buckled_i;
      in_d.sensor_buckled = sensor_buckled_i;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  // ---- step logic ---------------------------------------------------------
  state_t  step_state;
  result_t step_res;

  sbr_step u_step (
    .item_i   (in_q),
    .state_i  (state_q),
    .cfg_i    (cfg_q),
    .state_o  (step_state),
    .result_o (step_res)
  );

  // state commits only when the word moves into the result register
  assign state_d = advance ? step_state : state_q;

  always_comb begin
    out_valid_d = out_valid_q;
    res_d       = res_q;
    if (advance) begin
      out_valid_d = 1'b1;
      res_d       = step_res;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // ---- configuration ------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_LOW_SPEED:      cfg_d.low_speed      = cfg_data_i[SpeedW-1:0];
        CFG_SPEED_DURATION: cfg_d.speed_duration = cfg_data_i;
        CFG_BUZZER_DELAY:   cfg_d.buzzer_delay   = cfg_data_i;
        CFG_UNBUCKLE_LIMIT: cfg_d.unbuckle_limit = cfg_data_i;
        CFG_BUZZER_TIMEOUT: cfg_d.buzzer_timeout = cfg_data_i;
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // ---- registers ----------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q           <= 1'b0;
      out_valid_q          <= 1'b0;
      state_q.mode         <= MODE_IDLE;
      state_q.speed_timer  <= '0;
      state_q.belt_timer   <= '0;
      cfg_q.low_speed      <= LowSpeedRst;
      cfg_q.speed_duration <= SpeedDurationRst;
      cfg_q.buzzer_delay   <= BuzzerDelayRst;
      cfg_q.unbuckle_limit <= UnbuckleLimitRst;
      cfg_q.buzzer_timeout <= BuzzerTimeoutRst;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      state_q     <= state_d;
      cfg_q       <= cfg_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    in_q  <= in_d;
    res_q <= res_d;
  end

  // ---- outputs ------------------------------------------------------------
  assign out_valid_o    = out_valid_q;
  assign buzzer_cmd_o   = res_q.buzzer_cmd;
  assign buzz_seconds_o = res_q.buzz_seconds;
  assign message_o      = res_q.message;
  assign mode_o         = res_q.mode;

  // ---- assertions ---------------------------------------------------------
`ifndef SYNTHESIS
  // the belt counter only runs while armed or buzzing
  a_belt_timer_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(state_q.mode == MODE_ARMED || state_q.mode == MODE_BUZZING)
      |-> state_q.belt_timer == '0)
    else $error("belt timer running outside armed/buzzing");

  // a buzz duration goes out only with a buzz-on command
  a_buzz_seconds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && buzzer_cmd_o != CMD_ON |-> buzz_seconds_o == '0)
    else $error("buzz duration without buzz-on");

  // the belt-off message is only sent on entering reported
  a_msg_off_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && message_o == MSG_OFF |-> mode_o == ModeCodeReported)
    else $error("belt-off message outside reported");

  // state only moves when a word moves into the result register
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(state_q))
    else $error("state changed without a word");
`endif

endmodule
